// ===== sv/srl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record S1 loader package
// Shared types and codes for the character front, token queue and parser.
// ----------------------------------------------------------------------------
package srl_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [7:0] CHAR_ONE = 8'h31;

   localparam logic [7:0] MIN_COUNT = 8'd3;

   localparam logic [1:0] KIND_WRITE     = 2'd0;
   localparam logic [1:0] KIND_GOOD      = 2'd1;
   localparam logic [1:0] KIND_CSUM_ERR  = 2'd2;
   localparam logic [1:0] KIND_MALFORMED = 2'd3;

   // one classified character
   typedef struct packed {
      logic       is_nl;
      logic       is_s;
      logic       is_one;
      logic       is_hex;
      logic [3:0] nibble;
   } token_type;

endpackage

// ===== sv/srl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record front end
// Accepts characters, drops carriage returns and classifies the rest.
// ----------------------------------------------------------------------------
module srl_front (
   input  logic              req_push,
   input  logic [7:0]        req_text_char,
   output logic              req_full,
   input  logic              q_full,
   output logic              q_push,
   output srl_pkg::token_type q_token
);

   logic       is_cr;
   logic       hex_ok;
   logic [3:0] hex_val;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_text_char >= 8'h30 && req_text_char <= 8'h39) begin
         hex_val = 4'(req_text_char - 8'h30);
      end else if (req_text_char >= 8'h41 && req_text_char <= 8'h46) begin
         hex_val = 4'(req_text_char - 8'h37);
      end else if (req_text_char >= 8'h61 && req_text_char <= 8'h66) begin
         hex_val = 4'(req_text_char - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_cr    = (req_text_char == srl_pkg::CHAR_CR);
   assign req_full = q_full;
   assign q_push   = req_push && !q_full && !is_cr;

   assign q_token.is_nl  = (req_text_char == srl_pkg::CHAR_NL);
   assign q_token.is_s   = (req_text_char == srl_pkg::CHAR_S);
   assign q_token.is_one = (req_text_char == srl_pkg::CHAR_ONE);
   assign q_token.is_hex = hex_ok;
   assign q_token.nibble = hex_val;

endmodule

// ===== sv/srl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record token queue
// Small register-file FIFO between the front end and the parser.
// ----------------------------------------------------------------------------
module srl_queue #(
   parameter int Depth = srl_pkg::QUEUE_DEPTH,
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/srl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record parser
// Record state machine over classified characters, with a result register.
// ----------------------------------------------------------------------------
module srl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   input  srl_pkg::token_type tok,
   output logic               tok_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [1:0]         rsp_result_kind,
   output logic [15:0]        rsp_write_address,
   output logic [7:0]         rsp_write_data
);

   localparam logic [2:0] PH_LINE_START = 3'd0;
   localparam logic [2:0] PH_TYPE       = 3'd1;
   localparam logic [2:0] PH_COUNT      = 3'd2;
   localparam logic [2:0] PH_ADDR       = 3'd3;
   localparam logic [2:0] PH_DATA       = 3'd4;
   localparam logic [2:0] PH_CHECK      = 3'd5;
   localparam logic [2:0] PH_SKIP       = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic        pend_ff, pend_in;
   logic [3:0]  hi_ff, hi_in;
   logic        idx_ff, idx_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  sum_ff, sum_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [15:0] out_addr_ff, out_addr_in;
   logic [7:0]  out_data_ff, out_data_in;

   logic        take;
   logic        emit;
   logic [1:0]  e_kind;
   logic [15:0] e_addr;
   logic [7:0]  e_data;
   logic [7:0]  byte_val;
   logic [7:0]  left_dec;

   assign take     = tok_valid && (!out_valid_ff || rsp_pop);
   assign tok_pop  = take;
   assign byte_val = {hi_ff, tok.nibble};
   assign left_dec = left_ff - 8'd1;

   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      sum_in   = sum_ff;
      emit     = 1'b0;
      e_kind   = srl_pkg::KIND_WRITE;
      e_addr   = 16'd0;
      e_data   = 8'd0;
      if (take) begin
         unique case (phase_ff)
            PH_LINE_START: begin
               if (!tok.is_nl) begin
                  phase_in = tok.is_s ? PH_TYPE : PH_SKIP;
               end
            end
            PH_TYPE: begin
               if (tok.is_nl) begin
                  phase_in = PH_LINE_START;
               end else if (tok.is_one) begin
                  phase_in = PH_COUNT;
                  pend_in  = 1'b0;
                  hi_in    = 4'd0;
                  idx_in   = 1'b0;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK: begin
               if (!tok.is_hex) begin
                  pend_in  = 1'b0;
                  phase_in = tok.is_nl ? PH_LINE_START : PH_SKIP;
                  emit     = 1'b1;
                  e_kind   = srl_pkg::KIND_MALFORMED;
               end else if (!pend_ff) begin
                  hi_in   = tok.nibble;
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  unique case (phase_ff)
                     PH_COUNT: begin
                        if (byte_val < srl_pkg::MIN_COUNT) begin
                           phase_in = PH_SKIP;
                           emit     = 1'b1;
                           e_kind   = srl_pkg::KIND_MALFORMED;
                        end else begin
                           sum_in   = byte_val;
                           left_in  = byte_val - srl_pkg::MIN_COUNT;
                           idx_in   = 1'b0;
                           phase_in = PH_ADDR;
                        end
                     end
                     PH_ADDR: begin
                        sum_in = sum_ff + byte_val;
                        if (!idx_ff) begin
                           addr_in = {byte_val, 8'h00};
                           idx_in  = 1'b1;
                        end else begin
                           addr_in  = {addr_ff[15:8], byte_val};
                           idx_in   = 1'b0;
                           phase_in = (left_ff != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                     end
                     PH_DATA: begin
                        sum_in  = sum_ff + byte_val;
                        addr_in = addr_ff + 16'd1;
                        left_in = left_dec;
                        if (left_dec == 8'd0) begin
                           phase_in = PH_CHECK;
                        end
                        emit   = 1'b1;
                        e_kind = srl_pkg::KIND_WRITE;
                        e_addr = addr_ff;
                        e_data = byte_val;
                     end
                     default: begin
                        phase_in = PH_SKIP;
                        emit     = 1'b1;
                        e_kind   = (~sum_ff == byte_val) ? srl_pkg::KIND_GOOD
                                                         : srl_pkg::KIND_CSUM_ERR;
                     end
                  endcase
               end
            end
            default: begin
               if (tok.is_nl) begin
                  phase_in = PH_LINE_START;
               end
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      out_kind_in  = out_kind_ff;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = e_kind;
         out_addr_in  = e_addr;
         out_data_in  = e_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE_START;
         pend_ff      <= 1'b0;
         hi_ff        <= 4'd0;
         idx_ff       <= 1'b0;
         left_ff      <= 8'd0;
         addr_ff      <= 16'd0;
         sum_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         hi_ff        <= hi_in;
         idx_ff       <= idx_in;
         left_ff      <= left_in;
         addr_ff      <= addr_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_write_data    = out_data_ff;

endmodule

// ===== sv/srecord_s1_loader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record S1 loader
// Decodes S1 records from a character stream into memory-write words.
// ----------------------------------------------------------------------------
// Input: one ASCII character per word on req_text_char, taken when req_push
// is high and req_full is low. Output: queue-style; a word waits on the
// rsp_ ports while rsp_empty is low and leaves on rsp_pop.
// Each data byte of an S1 line gives a write word (kind 0); the checksum
// byte gives a good or checksum-error word; a bad digit or short count
// gives a malformed word. Other characters give no word.
// The front end classifies a character in the cycle it is taken and pushes
// it into a token queue of QueueDepth entries; the parser takes one token a
// cycle while the result register is empty or being popped, and loads the
// result register, so a result passes through the queue and then the result
// register. Sustained rate is one character per cycle while rsp_pop keeps
// up, set by the single-token parser step. Reset empties the queue and
// result register and returns to line start. While rsp_pop is held low the
// parser stops once a word waits in the result register, the queue fills and
// req_full rises after at most QueueDepth more characters other than carriage returns.
// ----------------------------------------------------------------------------
module srecord_s1_loader #(
   parameter int QueueDepth = srl_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_text_char,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_data
);

   localparam int TokW = $bits(srl_pkg::token_type);

   srl_pkg::token_type push_tok;
   srl_pkg::token_type pop_tok;
   logic               q_push;
   logic               q_full;
   logic               q_empty;
   logic               tok_valid;
   logic               tok_pop;

   srl_front u_front (
      .req_push      (req_push),
      .req_text_char (req_text_char),
      .req_full      (req_full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_token       (push_tok)
   );

   srl_queue #(
      .Depth (QueueDepth),
      .Width (TokW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_tok),
      .full      (q_full),
      .pop       (tok_pop),
      .pop_data  (pop_tok),
      .empty     (q_empty)
   );

   assign tok_valid = !q_empty;

   srl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .tok_valid         (tok_valid),
      .tok               (pop_tok),
      .tok_pop           (tok_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result word present after reset");

   a_tok_held: assert property (@(posedge clock) disable iff (reset)
      (tok_valid && !tok_pop) |=> tok_valid)
      else $error("token lost while parser stalled");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != srl_pkg::KIND_WRITE)
         |-> (rsp_write_address == 16'd0 && rsp_write_data == 8'd0))
      else $error("status word carries write payload");

endmodule

// ===== dv/srecord_s1_loader_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record S1 loader testbench
// Feeds S-record text into the loader one character per word. A short
// table of hand-written lines with their expected words comes first,
// then generated files checked against a cycle-free decoder: mostly
// well-formed S1 records with random content, plus broken records, other
// record types and raw byte noise. Both sides idle in random bursts, and
// the result side holds off once for long enough to back up the input.
// ----------------------------------------------------------------------------
module srecord_s1_loader_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RAND_CHARS   = 1110;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int DIR_ROWS     = 38;

   typedef enum logic [2:0] {
      LN_START, LN_TYPE, LN_COUNT, LN_ADDR, LN_DATA, LN_CHECK, LN_SKIP
   } line_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]   ch;
      logic         typed;
      rsp_word_type word;
   } text_row_type;

   localparam rsp_word_type NO_WORD   = '0;
   localparam rsp_word_type GOOD_WORD = '{srl_pkg::KIND_GOOD, 16'h0000, 8'h00};
   localparam rsp_word_type CSUM_WORD = '{srl_pkg::KIND_CSUM_ERR, 16'h0000, 8'h00};
   localparam rsp_word_type BAD_WORD  = '{srl_pkg::KIND_MALFORMED, 16'h0000, 8'h00};
   localparam rsp_word_type TOP_WRITE = '{srl_pkg::KIND_WRITE, 16'hFFFF, 8'hFF};

   // good record with trailing text, top-address write with bad checksum,
   // short count, newline inside a record, other type, empty line
   localparam text_row_type TEXT_ROWS [DIR_ROWS] = '{
      '{"S", 1'b0, NO_WORD}, '{"1", 1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
      '{"3", 1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD}, '{"F", 1'b0, NO_WORD},
      '{"C", 1'b1, GOOD_WORD}, '{"z", 1'b0, NO_WORD}, '{srl_pkg::CHAR_NL, 1'b0, NO_WORD},
      '{"S", 1'b0, NO_WORD}, '{"1", 1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
      '{"4", 1'b0, NO_WORD}, '{"F", 1'b0, NO_WORD}, '{"F", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD}, '{"F", 1'b0, NO_WORD}, '{"f", 1'b0, NO_WORD},
      '{"f", 1'b1, TOP_WRITE}, '{"F", 1'b0, NO_WORD}, '{"D", 1'b1, CSUM_WORD},
      '{srl_pkg::CHAR_CR, 1'b0, NO_WORD}, '{srl_pkg::CHAR_NL, 1'b0, NO_WORD},
      '{"S", 1'b0, NO_WORD}, '{"1", 1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
      '{"2", 1'b1, BAD_WORD}, '{srl_pkg::CHAR_NL, 1'b0, NO_WORD},
      '{"S", 1'b0, NO_WORD}, '{"1", 1'b0, NO_WORD}, '{srl_pkg::CHAR_NL, 1'b1, BAD_WORD},
      '{"S", 1'b0, NO_WORD}, '{"9", 1'b0, NO_WORD}, '{srl_pkg::CHAR_NL, 1'b0, NO_WORD},
      '{srl_pkg::CHAR_NL, 1'b0, NO_WORD}
   };

   logic        clock;
   logic        reset;
   logic        req_push;
   logic [7:0]  req_text_char;
   logic        req_full;
   logic        rsp_pop;
   logic        rsp_empty;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_write_address;
   logic [7:0]  rsp_write_data;

   line_phase_type ln_phase;
   logic        nib_pending;
   logic [3:0]  hi_nib;
   logic        addr_lo_next;
   logic [7:0]  bytes_due;
   logic [7:0]  csum_acc;
   logic [15:0] next_addr;

   rsp_word_type pending_words[$];
   logic [7:0]  stream_chars[$];
   logic [7:0]  line_buf[$];

   int errors = 0;
   int cycle_count;
   int hold_left;
   int rx_gap;
   int idle_odds;
   bit hold_req;
   bit calm;

   srecord_s1_loader dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_text_char     (req_text_char),
      .req_full          (req_full),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
      if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 8'd10)};
      if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 8'd10)};
      return 5'b0;
   endfunction

   task automatic decode_char(input logic [7:0] ch, output logic got,
                              output rsp_word_type w);
      logic [4:0] hv;
      logic [7:0] b;
      got = 1'b0;
      w = NO_WORD;
      if (ch == srl_pkg::CHAR_CR) return;
      case (ln_phase)
         LN_START: begin
            if (ch != srl_pkg::CHAR_NL)
               ln_phase = (ch == srl_pkg::CHAR_S) ? LN_TYPE : LN_SKIP;
         end
         LN_TYPE: begin
            if (ch == srl_pkg::CHAR_NL) begin
               ln_phase = LN_START;
            end else if (ch == srl_pkg::CHAR_ONE) begin
               ln_phase = LN_COUNT;
               nib_pending = 1'b0;
               hi_nib = 4'h0;
               addr_lo_next = 1'b0;
            end else begin
               ln_phase = LN_SKIP;
            end
         end
         LN_COUNT, LN_ADDR, LN_DATA, LN_CHECK: begin
            hv = hex_digit(ch);
            if (!hv[4]) begin
               nib_pending = 1'b0;
               ln_phase = (ch == srl_pkg::CHAR_NL) ? LN_START : LN_SKIP;
               got = 1'b1;
               w.kind = srl_pkg::KIND_MALFORMED;
            end else if (!nib_pending) begin
               hi_nib = hv[3:0];
               nib_pending = 1'b1;
            end else begin
               nib_pending = 1'b0;
               b = {hi_nib, hv[3:0]};
               case (ln_phase)
                  LN_COUNT: begin
                     if (b < srl_pkg::MIN_COUNT) begin
                        ln_phase = LN_SKIP;
                        got = 1'b1;
                        w.kind = srl_pkg::KIND_MALFORMED;
                     end else begin
                        csum_acc = b;
                        bytes_due = b - srl_pkg::MIN_COUNT;
                        addr_lo_next = 1'b0;
                        ln_phase = LN_ADDR;
                     end
                  end
                  LN_ADDR: begin
                     csum_acc = csum_acc + b;
                     if (!addr_lo_next) begin
                        next_addr = {b, 8'h00};
                        addr_lo_next = 1'b1;
                     end else begin
                        next_addr[7:0] = b;
                        addr_lo_next = 1'b0;
                        ln_phase = (bytes_due != 0) ? LN_DATA : LN_CHECK;
                     end
                  end
                  LN_DATA: begin
                     got = 1'b1;
                     w = '{srl_pkg::KIND_WRITE, next_addr, b};
                     csum_acc = csum_acc + b;
                     next_addr = next_addr + 16'd1;
                     bytes_due = bytes_due - 8'd1;
                     if (bytes_due == 0) ln_phase = LN_CHECK;
                  end
                  default: begin
                     ln_phase = LN_SKIP;
                     got = 1'b1;
                     w.kind = (8'(~csum_acc) == b) ? srl_pkg::KIND_GOOD
                                                   : srl_pkg::KIND_CSUM_ERR;
                  end
               endcase
            end
         end
         default: begin
            if (ch == srl_pkg::CHAR_NL) ln_phase = LN_START;
         end
      endcase
   endtask

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      errors++;
   endtask

   task automatic check_word();
      rsp_word_type exp_w;
      if (pending_words.size() == 0) begin
         flag_mismatch($sformatf("unexpected word kind %0d addr %h data %h",
                                 rsp_result_kind, rsp_write_address, rsp_write_data));
         return;
      end
      exp_w = pending_words.pop_front();
      if (rsp_result_kind !== exp_w.kind)
         flag_mismatch($sformatf("kind %0d, expected %0d", rsp_result_kind, exp_w.kind));
      if (rsp_write_address !== exp_w.addr)
         flag_mismatch($sformatf("addr %h, expected %h", rsp_write_address, exp_w.addr));
      if (rsp_write_data !== exp_w.data)
         flag_mismatch($sformatf("data %h, expected %h", rsp_write_data, exp_w.data));
   endtask

   // result side: pop decided at the falling edge, word taken at the rising edge
   initial begin
      rsp_pop = 1'b0;
      hold_left = 0;
      rx_gap = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 16) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) check_word();
      end
   end

   task automatic offer_char(input logic [7:0] ch);
      req_push <= 1'b1;
      req_text_char <= ch;
      do @(posedge clock); while (req_full);
   endtask

   task automatic idle_after();
      int gap;
      @(negedge clock);
      gap = 0;
      if (!calm && !hold_req && hold_left == 0 && idle_odds != 0 &&
          $urandom_range(1, idle_odds) == 1)
         gap = $urandom_range(1, 16);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic feed_char(input logic [7:0] ch, input logic typed,
                            input rsp_word_type tw);
      logic         got;
      rsp_word_type w;
      offer_char(ch);
      decode_char(ch, got, w);
      if (typed) pending_words.push_back(tw);
      else if (got) pending_words.push_back(w);
      idle_after();
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'("0") + 8'(n);
      return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
   endfunction

   task automatic put_byte(input logic [7:0] b);
      line_buf.push_back(hex_char(b[7:4]));
      line_buf.push_back(hex_char(b[3:0]));
   endtask

   function automatic int rec_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(7, 40);
      return $urandom_range(0, 6);
   endfunction

   task automatic gen_s1_line(input int n, input logic bad_sum);
      logic [15:0] a;
      logic [7:0]  sum;
      logic [7:0]  d;
      int          k;
      a = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                      : 16'($urandom);
      line_buf.delete();
      line_buf.push_back(srl_pkg::CHAR_S);
      line_buf.push_back(srl_pkg::CHAR_ONE);
      sum = 8'(n + 3);
      put_byte(sum);
      put_byte(a[15:8]);
      put_byte(a[7:0]);
      sum = sum + a[15:8] + a[7:0];
      for (k = 0; k < n; k++) begin
         d = 8'($urandom);
         put_byte(d);
         sum = sum + d;
      end
      d = ~sum;
      if (bad_sum) d = d ^ 8'($urandom_range(1, 255));
      put_byte(d);
   endtask

   initial begin
      int         i;
      int         p;
      int         line_no;
      int         pick;
      logic [7:0] c;
      logic [4:0] hv;

      reset = 1'b1;
      req_push = 1'b0;
      req_text_char = 8'h00;
      hold_req = 1'b0;
      calm = 1'b0;
      idle_odds = 3;
      ln_phase = LN_START;
      nib_pending = 1'b0;
      hi_nib = 4'h0;
      addr_lo_next = 1'b0;
      bytes_due = 8'h00;
      csum_acc = 8'h00;
      next_addr = 16'h0000;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         feed_char(TEXT_ROWS[i].ch, TEXT_ROWS[i].typed, TEXT_ROWS[i].word);

      line_no = 0;
      while (stream_chars.size() < RAND_CHARS) begin
         pick = $urandom_range(0, 99);
         if (line_no == 10) begin
            gen_s1_line(252, 1'b0);
         end else if (pick < 70) begin
            gen_s1_line(rec_len(), $urandom_range(0, 6) == 0);
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(32, 126)));
         end else if (pick < 80) begin
            if ($urandom_range(0, 2) == 0) begin
               line_buf.delete();
               line_buf.push_back(srl_pkg::CHAR_S);
               line_buf.push_back(srl_pkg::CHAR_ONE);
               put_byte(8'($urandom_range(0, 2)));
               repeat ($urandom_range(0, 4)) line_buf.push_back(hex_char(4'($urandom)));
            end else begin
               gen_s1_line(rec_len(), 1'b0);
               p = $urandom_range(2, line_buf.size() - 1);
               while (line_buf.size() > p) void'(line_buf.pop_back());
               do begin
                  c = 8'($urandom_range(0, 255));
                  hv = hex_digit(c);
               end while (hv[4] || c == srl_pkg::CHAR_CR);
               line_buf.push_back(c);
            end
         end else if (pick < 90) begin
            line_buf.delete();
            if ($urandom_range(0, 1)) begin
               line_buf.push_back(srl_pkg::CHAR_S);
               do c = 8'($urandom_range(32, 126)); while (c == srl_pkg::CHAR_ONE);
            end else begin
               do c = 8'($urandom_range(32, 126)); while (c == srl_pkg::CHAR_S);
            end
            line_buf.push_back(c);
            repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(32, 126)));
         end else begin
            line_buf.delete();
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
         foreach (line_buf[j]) stream_chars.push_back(line_buf[j]);
         if ($urandom_range(0, 2) == 0) stream_chars.push_back(srl_pkg::CHAR_CR);
         stream_chars.push_back(srl_pkg::CHAR_NL);
         line_no++;
      end

      for (i = 0; i < stream_chars.size(); i++) begin
         if (i % 100 == 0)
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
         if (i == 150) hold_req = 1'b1;
         calm = (i >= stream_chars.size() * 85 / 100);
         feed_char(stream_chars[i], 1'b0, NO_WORD);
      end
      req_push <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_words.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== srecord_s1_loader.f =====
sv/srl_pkg.sv
sv/srl_front.sv
sv/srl_queue.sv
sv/srl_back.sv
sv/srecord_s1_loader.sv
dv/srecord_s1_loader_tb.sv
